// File: src/can_signal_packer_core_assert.svh
// assertion macros for the signal packer checker
// needs clk and rst_n in the scope of use
`ifndef CAN_SIGNAL_PACKER_CORE_ASSERT_SVH
`define CAN_SIGNAL_PACKER_CORE_ASSERT_SVH

// antecedent this cycle, consequent in the same cycle
`define CSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent this cycle, consequent in the next cycle
`define CSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/can_sp_pkg.sv
// shared types and constants for the can signal packer
// no dependencies
package can_sp_pkg;

  localparam int MAX_MESSAGE_BYTES = 64;
  localparam int START_W    = 9;
  localparam int BLEN_W     = 7;
  localparam int MLEN_W     = 7;
  localparam int DATA_W     = 64;
  localparam int BYTE_IDX_W = 6;
  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_READ   = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BIT  = 3'd0,
    CFG_BIT_LENGTH = 3'd1,
    CFG_BIG_ENDIAN = 3'd2,
    CFG_MSG_LENGTH = 3'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_INS_RD,
    ST_INS_WR
  } state_t;

  typedef struct packed {
    logic [1:0]            mode;
    logic [BYTE_IDX_W-1:0] byte_index;
    logic [DATA_W-1:0]     data;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       status;
  } out_word_t;

  // sawtooth bit numbering, its own inverse
  function automatic logic [START_W-1:0] saw(input logic [START_W-1:0] p);
    saw = {p[START_W-1:3], ~p[2:0]};
  endfunction

endpackage

// File: src/can_sp_store.sv
// message byte store: synchronous memory with registered read
// entries read as zero until written; uses no package items
module can_sp_store #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [7:0]       rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : 8'd0;

endmodule

// File: src/can_signal_packer_core.sv
// can signal packer top level: control, configuration and insert datapath
// depends on can_sp_pkg and can_sp_store
//
//  channel  ports                          handshake
//  input    start, busy, in_word           taken when start high and busy low
//  result   out_strobe, out_word           one cycle strobe, always taken
//  config   cfg_we, cfg_index, cfg_data    taken when cfg_we high
//
// byte write: result the cycle after accept, next word taken then
// byte read: store read registered on accept, result registered from ST_READ; busy meanwhile
// insert over n bytes (n up to 17): each byte read in ST_INS_RD, then merged and written
//   in ST_INS_WR via the byte-wide store ports, busy until done; flagged or empty inserts stay idle
// reset clears the per-byte valid flags at once; no clearing pass
// results cannot be stalled and show for exactly one cycle
module can_signal_packer_core #(
  parameter int MAX_MESSAGE_BYTES = can_sp_pkg::MAX_MESSAGE_BYTES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  can_sp_pkg::in_word_t                in_word,
  output logic                                out_strobe,
  output can_sp_pkg::out_word_t               out_word,
  input  logic                                cfg_we,
  input  logic [can_sp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [can_sp_pkg::CFG_W-1:0]        cfg_data
);

  localparam int AW = $clog2(MAX_MESSAGE_BYTES);
  localparam int MLW = can_sp_pkg::MLEN_W;
  localparam logic [MLW-1:0] MAX_LEN = MLW'(MAX_MESSAGE_BYTES);
  localparam int SW = can_sp_pkg::START_W;
  localparam int LW = can_sp_pkg::BLEN_W;
  localparam int DW = can_sp_pkg::DATA_W;

  can_sp_pkg::state_t state_r, state_nxt;

  logic [SW-1:0]  first_bit_r;
  logic [LW-1:0]  bit_length_r;
  logic           big_endian_r;
  logic [MLW-1:0] message_length_r;

  logic [MLW-1:0] idx_r, idx_nxt;
  logic [LW-1:0]  bits_r, bits_nxt;
  logic [2:0]     shift_r, shift_nxt;
  logic           first_r, first_nxt;
  logic [DW-1:0]  value_r, value_nxt;
  logic           rd_ok_r, rd_ok_nxt;
  logic           out_strobe_r, out_strobe_nxt;
  can_sp_pkg::out_word_t out_word_r, out_word_nxt;

  logic           accept;
  logic [MLW-1:0] eff_len;
  logic           more;
  logic           ins_zero;
  logic           ins_flag;
  logic [SW-1:0]  ins_lsb;
  logic [SW:0]    moto_pos;
  logic [SW:0]    intel_end;
  logic [DW-1:0]  len_mask;

  logic [2:0]     cur_shift;
  logic [3:0]     avail;
  logic [3:0]     size;
  logic [7:0]     low_mask;
  logic [7:0]     byte_mask;
  logic [7:0]     merged;

  logic           st_wr_en;
  logic [AW-1:0]  st_wr_addr;
  logic [7:0]     st_wr_data;
  logic           st_rd_en;
  logic [AW-1:0]  st_rd_addr;
  logic [7:0]     st_rd_data;

  assign accept  = start && (state_r == can_sp_pkg::ST_IDLE);
  assign busy    = (state_r != can_sp_pkg::ST_IDLE);
  assign eff_len = (message_length_r < MAX_LEN) ? message_length_r : MAX_LEN;
  assign more    = (idx_r < eff_len) && (bits_r != '0);

  // insert placement
  assign ins_zero  = (bit_length_r == '0);
  assign moto_pos  = {1'b0, can_sp_pkg::saw(first_bit_r)} + {3'b000, bit_length_r} - 10'd1;
  assign intel_end = {1'b0, first_bit_r} + {3'b000, bit_length_r} - 10'd1;
  assign ins_flag  = big_endian_r ? moto_pos[SW] : intel_end[SW];
  assign ins_lsb   = big_endian_r ? can_sp_pkg::saw(moto_pos[SW-1:0]) : first_bit_r;
  assign len_mask  = (bit_length_r >= 7'd64) ? {DW{1'b1}} : ~({DW{1'b1}} << bit_length_r);

  // byte merge
  assign cur_shift = first_r ? shift_r : 3'd0;
  assign avail     = 4'd8 - {1'b0, cur_shift};
  assign size      = (bits_r < {3'b000, avail}) ? bits_r[3:0] : avail;
  assign low_mask  = 8'hFF >> (4'd8 - size);
  assign byte_mask = low_mask << cur_shift;
  assign merged    = (st_rd_data & ~byte_mask) | ((value_r[7:0] & low_mask) << cur_shift);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      can_sp_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_word.mode)
            can_sp_pkg::MODE_READ:   state_nxt = can_sp_pkg::ST_READ;
            can_sp_pkg::MODE_INSERT: begin
              if (!ins_zero && !ins_flag) begin
                state_nxt = can_sp_pkg::ST_INS_RD;
              end
            end
            can_sp_pkg::MODE_WRITE:  state_nxt = can_sp_pkg::ST_IDLE;
            can_sp_pkg::MODE_NONE:   state_nxt = can_sp_pkg::ST_IDLE;
            default:                 state_nxt = can_sp_pkg::ST_IDLE;
          endcase
        end
      end
      can_sp_pkg::ST_READ:   state_nxt = can_sp_pkg::ST_IDLE;
      can_sp_pkg::ST_INS_RD: state_nxt = more ? can_sp_pkg::ST_INS_WR : can_sp_pkg::ST_IDLE;
      can_sp_pkg::ST_INS_WR: state_nxt = can_sp_pkg::ST_INS_RD;
      default:               state_nxt = can_sp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt        = idx_r;
    bits_nxt       = bits_r;
    shift_nxt      = shift_r;
    first_nxt      = first_r;
    value_nxt      = value_r;
    rd_ok_nxt      = rd_ok_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    st_wr_en       = 1'b0;
    st_wr_addr     = idx_r[AW-1:0];
    st_wr_data     = merged;
    st_rd_en       = 1'b0;
    st_rd_addr     = idx_r[AW-1:0];
    unique case (state_r)
      can_sp_pkg::ST_IDLE: begin
        if (accept) begin
          out_word_nxt.read_byte = 8'd0;
          out_word_nxt.status    = 1'b0;
          unique case (in_word.mode)
            can_sp_pkg::MODE_WRITE: begin
              st_wr_en       = ({1'b0, in_word.byte_index} < eff_len);
              st_wr_addr     = in_word.byte_index[AW-1:0];
              st_wr_data     = in_word.data[7:0];
              out_strobe_nxt = 1'b1;
            end
            can_sp_pkg::MODE_READ: begin
              rd_ok_nxt  = ({1'b0, in_word.byte_index} < MAX_LEN);
              st_rd_en   = rd_ok_nxt;
              st_rd_addr = in_word.byte_index[AW-1:0];
            end
            can_sp_pkg::MODE_INSERT: begin
              idx_nxt   = {1'b0, ins_lsb[SW-1:3]};
              shift_nxt = ins_lsb[2:0];
              bits_nxt  = bit_length_r;
              first_nxt = 1'b1;
              value_nxt = in_word.data & len_mask;
              if (ins_zero || ins_flag) begin
                out_strobe_nxt      = 1'b1;
                out_word_nxt.status = !ins_zero;
              end
            end
            can_sp_pkg::MODE_NONE: out_strobe_nxt = 1'b1;
            default:               out_strobe_nxt = 1'b1;
          endcase
        end
      end
      can_sp_pkg::ST_READ: begin
        out_strobe_nxt         = 1'b1;
        out_word_nxt.read_byte = rd_ok_r ? st_rd_data : 8'd0;
        out_word_nxt.status    = 1'b0;
      end
      can_sp_pkg::ST_INS_RD: begin
        if (more) begin
          st_rd_en = 1'b1;
        end else begin
          out_strobe_nxt         = 1'b1;
          out_word_nxt.read_byte = 8'd0;
          out_word_nxt.status    = 1'b0;
        end
      end
      can_sp_pkg::ST_INS_WR: begin
        st_wr_en  = 1'b1;
        bits_nxt  = bits_r - {3'b000, size};
        value_nxt = value_r >> size;
        first_nxt = 1'b0;
        idx_nxt   = big_endian_r ? (idx_r - 7'd1) : (idx_r + 7'd1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= can_sp_pkg::ST_IDLE;
      out_strobe_r     <= 1'b0;
      first_bit_r      <= '0;
      bit_length_r     <= 7'd8;
      big_endian_r     <= 1'b0;
      message_length_r <= 7'd8;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          can_sp_pkg::CFG_START_BIT:  first_bit_r      <= cfg_data[SW-1:0];
          can_sp_pkg::CFG_BIT_LENGTH: bit_length_r     <= cfg_data[LW-1:0];
          can_sp_pkg::CFG_BIG_ENDIAN: big_endian_r     <= cfg_data[0];
          can_sp_pkg::CFG_MSG_LENGTH: message_length_r <= cfg_data[MLW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    bits_r     <= bits_nxt;
    shift_r    <= shift_nxt;
    first_r    <= first_nxt;
    value_r    <= value_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_word_r <= out_word_nxt;
  end

  can_sp_store #(
    .DEPTH (MAX_MESSAGE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

// File: src/can_sp_checker.sv
// port level checks for the can signal packer, bound to the top level
// depends on can_sp_pkg and can_signal_packer_core_assert.svh
`include "can_signal_packer_core_assert.svh"

module can_sp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_strobe,
  input can_sp_pkg::out_word_t            out_word
);

  logic in_taken;
  assign in_taken = start && !busy;

  `CSP_ASSERT_NEXT(a_accept_answered, in_taken, busy || out_strobe, "accepted word left no trace")
  `CSP_ASSERT_NOW(a_strobe_idle, out_strobe, !busy, "result shown while still busy")
  `CSP_ASSERT_NOW(a_flag_no_data, out_strobe && out_word.status, out_word.read_byte == 8'd0, "flagged result carries data")
  `CSP_ASSERT_NOW(a_strobe_cause, out_strobe, $past(busy) || $past(in_taken), "result with no word in flight")

endmodule

bind can_signal_packer_core can_sp_checker u_can_sp_checker (.*);
